// ----- design/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants for the text clause splitter.
// ----------------------------------------------------------------------------
package tcs_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } tcs_in_t;

    typedef struct packed {
        logic [7:0] clause_byte;
        logic       clause_end;
        logic [1:0] clause_kind;
        logic       run_end;
    } tcs_out_t;

    typedef struct packed {
        logic [7:0] prior_byte;
        logic       prior_in_clause;
        logic       skipping_blanks;
        logic [1:0] ellipsis_left;
    } tcs_state_t;

    localparam logic [1:0] KIND_PERIOD   = 2'd0;
    localparam logic [1:0] KIND_QUESTION = 2'd1;
    localparam logic [1:0] KIND_EXCLAIM  = 2'd2;
    localparam logic [1:0] KIND_COMMA    = 2'd3;

    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
    localparam logic [7:0] CHAR_EXCLAIM   = 8'h21;
    localparam logic [7:0] CHAR_COMMA     = 8'h2C;
    localparam logic [7:0] CHAR_PERIOD    = 8'h2E;
    localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] ELLIPSIS_0     = 8'hE2;
    localparam logic [7:0] ELLIPSIS_1     = 8'h80;
    localparam logic [7:0] ELLIPSIS_2     = 8'hA6;
    localparam logic [1:0] ELLIPSIS_RUN   = 2'd2;

    localparam tcs_state_t STATE_RESET = '{
        prior_byte:      8'h00,
        prior_in_clause: 1'b0,
        skipping_blanks: 1'b1,
        ellipsis_left:   2'd0
    };

    function automatic logic is_blank(input logic [7:0] b);
        is_blank = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) || (b == CHAR_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

endpackage

// ----- design/tcs_decide.sv -----
// ----------------------------------------------------------------------------
// tcs_decide
// Classifies one byte from its neighbours and the clause state, and gives the
// updated clause state.
// ----------------------------------------------------------------------------
module tcs_decide (
    input  logic               en,
    input  tcs_pkg::tcs_state_t st,
    input  logic [7:0]         cur,
    input  logic               h1,
    input  logic [7:0]         n1,
    input  logic               h2,
    input  logic [7:0]         n2,
    output tcs_pkg::tcs_state_t st_next,
    output logic               emit,
    output tcs_pkg::tcs_out_t  res
);
    import tcs_pkg::*;

    logic       is_end;
    logic [1:0] kind;
    logic       prev_digit;
    logic       next_digit;
    logic       ordinal;
    logic       ellipsis_start;
    tcs_state_t st_mid;

    assign prev_digit     = st.prior_in_clause && is_digit(st.prior_byte);
    assign next_digit     = h1 && is_digit(n1);
    assign ordinal        = (cur == CHAR_PERIOD) && prev_digit && h1 && (n1 == CHAR_SPACE)
                            && h2 && is_letter(n2);
    assign ellipsis_start = (cur == ELLIPSIS_0) && h1 && (n1 == ELLIPSIS_1)
                            && h2 && (n2 == ELLIPSIS_2);

    always_comb
    begin
        is_end  = 1'b0;
        kind    = KIND_PERIOD;
        emit    = 1'b0;
        st_mid  = st;
        st_next = st;
        if (en)
        begin
            emit = 1'b1;
            if (st.ellipsis_left != 2'd0)
            begin
                st_mid.ellipsis_left = st.ellipsis_left - 2'd1;
                is_end = (st.ellipsis_left == 2'd1);
            end
            else if (st.skipping_blanks && is_blank(cur))
            begin
                emit = 1'b0;
            end
            else
            begin
                st_mid.skipping_blanks = 1'b0;
                if (cur == CHAR_QUESTION)
                begin
                    is_end = 1'b1;
                    kind   = KIND_QUESTION;
                end
                else if (cur == CHAR_EXCLAIM)
                begin
                    is_end = 1'b1;
                    kind   = KIND_EXCLAIM;
                end
                else if ((cur == CHAR_COMMA) || (cur == CHAR_PERIOD))
                begin
                    if (!(prev_digit && next_digit) && !ordinal)
                    begin
                        is_end = 1'b1;
                        kind   = (cur == CHAR_COMMA) ? KIND_COMMA : KIND_PERIOD;
                    end
                end
                else if (ellipsis_start)
                begin
                    st_mid.ellipsis_left = ELLIPSIS_RUN;
                end
                else if ((cur == CHAR_SEMICOLON) || (cur == CHAR_COLON))
                begin
                    if (!h1 || is_blank(n1))
                    begin
                        is_end = 1'b1;
                        kind   = KIND_COMMA;
                    end
                end
            end
            if (emit)
            begin
                st_next = st_mid;
                if (is_end)
                begin
                    st_next.skipping_blanks = 1'b1;
                    st_next.prior_in_clause = 1'b0;
                end
                else
                begin
                    st_next.prior_byte      = cur;
                    st_next.prior_in_clause = 1'b1;
                end
            end
        end
    end

    assign res.clause_byte = cur;
    assign res.clause_end  = is_end;
    assign res.clause_kind = is_end ? kind : KIND_PERIOD;
    assign res.run_end     = 1'b0;

endmodule

// ----- design/text_clause_splitter.sv -----
// ----------------------------------------------------------------------------
// text_clause_splitter
// Splits a UTF-8 byte stream into clauses, dropping leading whitespace and
// marking each clause end with its kind.
// ----------------------------------------------------------------------------
// One text byte is accepted per cycle while the input is not stalled. A byte
// is decided once the two bytes after it have arrived, so results trail the
// input by two bytes until the final byte of a text flushes the window. An
// accepted transaction is held in an input register until the result queue
// has room, and is then decided into a four-entry result queue, from whose
// head results are offered. The queue drains one result per cycle while
// the receiver does not stall, which sets the sustained rate of one byte
// per cycle. A final byte can yield up to three results, and input is
// stalled as the queue makes room for them; receiver stalls lengthen this.
// ----------------------------------------------------------------------------
module text_clause_splitter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             text_valid,
    output logic             text_stall,
    input  tcs_pkg::tcs_in_t  text_data,
    output logic             clause_valid,
    input  logic             clause_stall,
    output tcs_pkg::tcs_out_t clause_data
);
    import tcs_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QW     = $clog2(QDEPTH);
    localparam int SLOTS  = 3;

    tcs_in_t          stage_reg;
    logic             stage_valid_reg;
    logic             stage_valid_next;
    logic [7:0]       window_reg [2];
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    tcs_state_t       state_reg;
    tcs_state_t       state_next;

    tcs_out_t         q_reg [QDEPTH];
    logic [QW-1:0]    head_reg;
    logic [QW:0]      count_reg;
    logic [QW:0]      count_next;
    logic [QW-1:0]    tail;

    logic             accept;
    logic             advance;
    logic             pop;

    logic [7:0]       seq [SLOTS];
    logic [1:0]       count_seq;
    logic             slot_en [SLOTS];
    logic             slot_h1 [SLOTS];
    logic             slot_h2 [SLOTS];
    tcs_state_t       chain [SLOTS+1];
    logic             emit [SLOTS];
    tcs_out_t         res [SLOTS];
    tcs_out_t         comp [SLOTS];
    logic [1:0]       npush;

    assign advance    = stage_valid_reg && (count_reg <= (QW+1)'(1));
    assign text_stall = stage_valid_reg && !advance;
    assign accept     = text_valid && !text_stall;
    assign pop        = (count_reg != '0) && !clause_stall;
    assign tail       = head_reg + count_reg[QW-1:0];

    assign clause_valid = (count_reg != '0);
    assign clause_data  = q_reg[head_reg];

    // Bytes in arrival order: window contents, then the staged byte.
    always_comb
    begin
        seq[0] = stage_reg.text_byte;
        seq[1] = stage_reg.text_byte;
        seq[2] = stage_reg.text_byte;
        case (fill_reg)
            2'd1:
            begin
                seq[0] = window_reg[0];
            end
            2'd2:
            begin
                seq[0] = window_reg[0];
                seq[1] = window_reg[1];
            end
            default:
            begin
                seq[0] = stage_reg.text_byte;
            end
        endcase
        count_seq = (fill_reg == 2'd2) ? 2'd3 : fill_reg + 2'd1;
    end

    assign chain[0] = state_reg;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_slot
        assign slot_h1[i] = (i + 1) < int'(count_seq);
        assign slot_h2[i] = (i + 2) < int'(count_seq);
        assign slot_en[i] = stage_valid_reg &&
                            (stage_reg.text_last ? (i < int'(count_seq))
                                                 : ((i == 0) && (fill_reg == 2'd2)));

        tcs_decide u_decide (
            .en      (slot_en[i]),
            .st      (chain[i]),
            .cur     (seq[i]),
            .h1      (slot_h1[i]),
            .n1      (seq[(i + 1) % SLOTS]),
            .h2      (slot_h2[i]),
            .n2      (seq[(i + 2) % SLOTS]),
            .st_next (chain[i+1]),
            .emit    (emit[i]),
            .res     (res[i])
        );
    end

    // Pack the emitted results in order, mark the last of the run, and close an open clause at the end of a text.
    always_comb
    begin
        npush = 2'd0;
        for (int k = 0; k < SLOTS; k++)
        begin
            comp[k] = '0;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (emit[i])
            begin
                comp[npush] = res[i];
                npush       = npush + 2'd1;
            end
        end
        if (npush != 2'd0)
        begin
            comp[npush - 2'd1].run_end = 1'b1;
            if (stage_reg.text_last && !chain[SLOTS].skipping_blanks)
            begin
                comp[npush - 2'd1].clause_end  = 1'b1;
                comp[npush - 2'd1].clause_kind = KIND_PERIOD;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        stage_valid_next = stage_valid_reg;
        if (advance)
        begin
            stage_valid_next = 1'b0;
            if (stage_reg.text_last)
            begin
                state_next = STATE_RESET;
                fill_next  = 2'd0;
            end
            else
            begin
                state_next = chain[SLOTS];
                fill_next  = (fill_reg == 2'd2) ? 2'd2 : fill_reg + 2'd1;
            end
        end
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        count_next = count_reg + (advance ? (QW+1)'(npush) : '0) - (QW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            fill_reg        <= 2'd0;
            state_reg       <= STATE_RESET;
            head_reg        <= '0;
            count_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            fill_reg        <= fill_next;
            state_reg       <= state_next;
            count_reg       <= count_next;
            if (pop)
            begin
                head_reg <= head_reg + QW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= text_data;
        end
        if (advance && !stage_reg.text_last)
        begin
            if (fill_reg == 2'd2)
            begin
                window_reg[0] <= window_reg[1];
                window_reg[1] <= stage_reg.text_byte;
            end
            else
            begin
                window_reg[fill_reg[0]] <= stage_reg.text_byte;
            end
        end
        if (advance)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                if (2'(k) < npush)
                begin
                    q_reg[tail + QW'(k)] <= comp[k];
                end
            end
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QW+1)'(QDEPTH))
        else $error("result queue overfilled");

    a_one_result_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !stage_reg.text_last |-> npush <= 2'd1)
        else $error("more than one result for a byte inside the text");

    a_flush_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_reg.text_last |=> fill_reg == 2'd0 && state_reg.skipping_blanks)
        else $error("state not cleared after end of text");

    a_ellipsis_in_clause: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.ellipsis_left != 2'd0 |-> !state_reg.skipping_blanks)
        else $error("ellipsis pending outside a clause");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 2'd2)
        else $error("lookahead window count out of range");

endmodule
